@@ sv/fsmc_pkg.sv @@
// ----------------------------------------------------------------------------
// Flash save memory controller package
// Opcodes, transaction kinds, modes and status words shared by the design.
// ----------------------------------------------------------------------------
package fsmc_pkg;

  // transaction kinds carried in tuser
  localparam logic [1:0] KIND_CMD       = 2'd0;
  localparam logic [1:0] KIND_STATUS_RD = 2'd1;
  localparam logic [1:0] KIND_DMA_RD    = 2'd2;
  localparam logic [1:0] KIND_DMA_WR    = 2'd3;

  // command opcodes (command word bits 31..24)
  localparam logic [7:0] OP_EXEC      = 8'hD2;
  localparam logic [7:0] OP_STATUS    = 8'hE1;
  localparam logic [7:0] OP_READ      = 8'hF0;
  localparam logic [7:0] OP_READ_ALT  = 8'h00;
  localparam logic [7:0] OP_LATCH     = 8'h4B;
  localparam logic [7:0] OP_ERASE     = 8'h78;
  localparam logic [7:0] OP_WRITE     = 8'hB4;
  localparam logic [7:0] OP_LATCH_ID  = 8'hA5;

  localparam logic [63:0] STATUS_STATUS = 64'h1111_8001_00C2_001E;
  localparam logic [63:0] STATUS_READ   = 64'h1111_8004_F000_0000;
  localparam logic [63:0] STATUS_ERASE  = 64'h1111_8008_00C2_001E;
  localparam logic [63:0] STATUS_ID     = 64'h1111_8004_00C2_001E;

  localparam logic [31:0] STATUS_REG_ADDR = 32'h0800_0000;
  localparam logic [31:0] ERASED_WORD     = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_READ   = 3'd1,
    MODE_STATUS = 3'd2,
    MODE_ERASE  = 3'd3,
    MODE_WRITE  = 3'd4
  } mode_t;

endpackage

@@ sv/fsmc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fsmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/flash_save_memory_controller.sv @@
// ----------------------------------------------------------------------------
// Flash save memory controller
// Command-driven flash save memory with page buffer, erase and program.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  s_axis   | in        | s_axis_tvalid/tready  | tuser kind, tdata fields
//  m_axis   | out       | m_axis_tvalid/tready  | tdata read_data, tuser error
//  cfg      | in        | cfg_valid/cfg_ready   | cfg_data read_only
//
// Commands, status reads, DMA writes and status-mode DMA reads: result in the
// cycle after acceptance. Flash DMA reads pass through ST_RD1, and also ST_RD2
// when the byte address is 2 mod 4 (two reads on the single flash read port).
// Page erase/program holds s_axis_tready low through ST_PROG and ST_DRAIN while
// all ones (erase) or the page buffer (program) go into flash, one word a cycle.
// After rst the flash is swept to all ones in ST_CLEAR, with s_axis_tready low;
// cfg writes are taken throughout.
// A result waiting on m_axis holds s_axis_tready low until m_axis_tready.
// ----------------------------------------------------------------------------
module flash_save_memory_controller
  import fsmc_pkg::*;
#(
  parameter int PAGE_WORDS  = 32,
  parameter int FLASH_PAGES = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command_word, bus_address, start_offset, word_index, transfer_length,
  // write_data, one pad bit
  input  logic [143:0] s_axis_tdata,
  // kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // read_data
  output logic [31:0]  m_axis_tdata,
  // error
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data
);

  localparam int ARRAY_WORDS = FLASH_PAGES * PAGE_WORDS;
  localparam int AW = $clog2(ARRAY_WORDS);
  localparam int CW = $clog2(PAGE_WORDS);
  localparam logic [31:0] ARRAY_BYTES = 32'(ARRAY_WORDS * 4);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RUN,
    ST_RD1,
    ST_RD2,
    ST_PROG,
    ST_DRAIN
  } state_t;

  state_t          state;
  mode_t           mode;
  logic            read_only;
  logic [63:0]     status_word;
  logic [15:0]     page_index;
  logic [AW-1:0]   fl_ptr;
  logic [CW-1:0]   cnt;
  logic            prog_erase;
  logic            prog_wr_valid;
  logic [AW-1:0]   prog_wr_addr;
  logic            rd_split;
  logic [AW-1:0]   rd_w_next;
  logic [15:0]     rd_hi;
  logic            out_valid;
  logic [31:0]     out_data;
  logic            out_err;

  logic [1:0]      kind;
  logic [31:0]     command_word;
  logic [31:0]     bus_address;
  logic [15:0]     start_offset;
  logic [13:0]     word_index;
  logic [16:0]     transfer_length;
  logic [31:0]     write_data;
  logic [7:0]      op;
  logic            in_acc;

  logic [16:0]     len_sat;
  logic [15:0]     idx4;
  logic [17:0]     addr;
  logic [18:0]     addr_end;
  logic [15:0]     word_addr;
  logic            rd_bad;
  logic            page_bad;
  logic            prog_mode;
  logic            pb_ok;

  logic            fl_we;
  logic [AW-1:0]   fl_wr_addr;
  logic [31:0]     fl_wr_data;
  logic [AW-1:0]   fl_rd_addr;
  logic [31:0]     fl_rd_data;
  logic            pb_we;
  logic [31:0]     pb_rd_data;

  assign kind            = s_axis_tuser;
  assign command_word    = s_axis_tdata[31:0];
  assign bus_address     = s_axis_tdata[63:32];
  assign start_offset    = s_axis_tdata[79:64];
  assign word_index      = s_axis_tdata[93:80];
  assign transfer_length = s_axis_tdata[110:94];
  assign write_data      = s_axis_tdata[142:111];
  assign op              = command_word[31:24];

  assign s_axis_tready = (state == ST_RUN) && (!out_valid || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_err;

  always_comb begin
    len_sat   = transfer_length[16] ? 17'h1_0000 : transfer_length;
    idx4      = {word_index, 2'b00};
    addr      = {1'b0, start_offset, 1'b0} + {2'b00, idx4};
    addr_end  = {1'b0, addr} + 19'd4;
    word_addr = addr[17:2];
    rd_bad    = (len_sat[1:0] != 2'b00) || ({1'b0, idx4} >= len_sat)
                || (32'(addr_end) > ARRAY_BYTES);
    page_bad  = {1'b0, page_index} >= 17'(FLASH_PAGES);
    prog_mode = (mode == MODE_ERASE) || (mode == MODE_WRITE);
    pb_ok     = (mode == MODE_WRITE) && (word_index < 14'(PAGE_WORDS));
    pb_we     = in_acc && (kind == KIND_DMA_WR) && pb_ok;
  end

  always_comb begin
    fl_we      = prog_wr_valid;
    fl_wr_addr = prog_wr_addr;
    fl_wr_data = prog_erase ? ERASED_WORD : pb_rd_data;
    if (state == ST_CLEAR) begin
      fl_we      = 1'b1;
      fl_wr_addr = fl_ptr;
      fl_wr_data = ERASED_WORD;
    end
    fl_rd_addr = (state == ST_RD1) ? rd_w_next : AW'(word_addr);
  end

  fsmc_ram #(
    .WIDTH (32),
    .DEPTH (ARRAY_WORDS)
  ) u_flash (
    .clk     (clk),
    .wr_en   (fl_we),
    .wr_addr (fl_wr_addr),
    .wr_data (fl_wr_data),
    .rd_addr (fl_rd_addr),
    .rd_data (fl_rd_data)
  );

  fsmc_ram #(
    .WIDTH (32),
    .DEPTH (PAGE_WORDS)
  ) u_page_buf (
    .clk     (clk),
    .wr_en   (pb_we),
    .wr_addr (CW'(word_index)),
    .wr_data (write_data),
    .rd_addr (cnt),
    .rd_data (pb_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      mode          <= MODE_IDLE;
      read_only     <= 1'b0;
      status_word   <= '0;
      page_index    <= '0;
      fl_ptr        <= '0;
      cnt           <= '0;
      prog_wr_valid <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        read_only <= cfg_data;
      end
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      prog_wr_valid <= 1'b0;

      unique case (state)
        ST_CLEAR: begin
          fl_ptr <= fl_ptr + 1'b1;
          if (fl_ptr == AW'(ARRAY_WORDS - 1)) begin
            state <= ST_RUN;
          end
        end

        ST_RUN: begin
          if (in_acc) begin
            out_valid <= 1'b1;
            out_data  <= '0;
            out_err   <= 1'b0;
            unique case (kind)
              KIND_CMD: begin
                unique case (op)
                  OP_EXEC: begin
                    mode    <= MODE_IDLE;
                    out_err <= prog_mode && page_bad;
                    if (prog_mode && !page_bad && !read_only) begin
                      state      <= ST_PROG;
                      fl_ptr     <= AW'(page_index * PAGE_WORDS);
                      cnt        <= '0;
                      prog_erase <= (mode == MODE_ERASE);
                    end
                  end
                  OP_STATUS: begin
                    mode        <= MODE_STATUS;
                    status_word <= STATUS_STATUS;
                  end
                  OP_READ, OP_READ_ALT: begin
                    mode        <= MODE_READ;
                    status_word <= STATUS_READ;
                  end
                  OP_LATCH: begin
                    page_index <= command_word[15:0];
                  end
                  OP_ERASE: begin
                    mode        <= MODE_ERASE;
                    status_word <= STATUS_ERASE;
                  end
                  OP_WRITE: begin
                    mode <= MODE_WRITE;
                  end
                  OP_LATCH_ID: begin
                    page_index  <= command_word[15:0];
                    status_word <= STATUS_ID;
                  end
                  default: begin
                    out_err <= 1'b1;
                  end
                endcase
              end
              KIND_STATUS_RD: begin
                out_data <= status_word[63:32];
                out_err  <= (bus_address != STATUS_REG_ADDR);
              end
              KIND_DMA_RD: begin
                if (mode == MODE_STATUS) begin
                  if (word_index == 14'd0) begin
                    out_data <= status_word[63:32];
                  end else if (word_index == 14'd1) begin
                    out_data <= status_word[31:0];
                  end else begin
                    out_err <= 1'b1;
                  end
                end else if ((mode == MODE_READ) && !rd_bad) begin
                  out_valid <= 1'b0;
                  state     <= ST_RD1;
                  rd_split  <= addr[1];
                  rd_w_next <= AW'(word_addr) + 1'b1;
                end else begin
                  out_err <= 1'b1;
                end
              end
              KIND_DMA_WR: begin
                out_err <= !pb_ok;
              end
              default: begin
                out_err <= 1'b1;
              end
            endcase
          end
        end

        ST_RD1: begin
          if (rd_split) begin
            rd_hi <= fl_rd_data[15:0];
            state <= ST_RD2;
          end else begin
            out_data  <= fl_rd_data;
            out_err   <= 1'b0;
            out_valid <= 1'b1;
            state     <= ST_RUN;
          end
        end

        ST_RD2: begin
          out_data  <= {rd_hi, fl_rd_data[31:16]};
          out_err   <= 1'b0;
          out_valid <= 1'b1;
          state     <= ST_RUN;
        end

        ST_PROG: begin
          prog_wr_valid <= 1'b1;
          prog_wr_addr  <= fl_ptr;
          fl_ptr        <= fl_ptr + 1'b1;
          cnt           <= cnt + 1'b1;
          if (cnt == CW'(PAGE_WORDS - 1)) begin
            state <= ST_DRAIN;
          end
        end

        ST_DRAIN: begin
          state <= ST_RUN;
        end

        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

endmodule
